@@ rtl/gem_pkg.sv @@
// gem_pkg: widths, register codes, controller states and control structs
// for the gated exponential mean unit. No dependencies.
package gem_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int ALPHA_BITS    = 16;
	localparam int MEAN_BITS     = SAMPLE_BITS + ALPHA_BITS;
	localparam int QUANT_BITS    = 23;
	localparam int RECIP_BITS    = 25;
	localparam int RECIP_SHIFT   = 24;
	localparam int MUL_BITS      = 26;
	localparam int PROD_BITS     = 2 * MUL_BITS;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 25;
	localparam int OUT_DATA_BITS = 2 * SAMPLE_BITS;

	localparam logic [ALPHA_BITS-1:0] ALPHA_RESET   = ALPHA_BITS'(62259);
	localparam logic [QUANT_BITS-1:0] QUANT_RESET   = QUANT_BITS'(26);
	localparam logic [RECIP_BITS-1:0] RECIP_RESET   = RECIP_BITS'(645278);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ALPHA = 3'd0,
		CFG_LOWER = 3'd1,
		CFG_UPPER = 3'd2,
		CFG_QUANT = 3'd3,
		CFG_RECIP = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic        [ALPHA_BITS-1:0]  alpha;
		logic signed [SAMPLE_BITS-1:0] lower;
		logic signed [SAMPLE_BITS-1:0] upper;
		logic        [QUANT_BITS-1:0]  quantum;
		logic        [RECIP_BITS-1:0]  recip;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_U1,
		ST_U2,
		ST_U3,
		ST_U4,
		ST_R1,
		ST_R2,
		ST_R3,
		ST_R4,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_LF_ALPHA  = 3'd0,
		MUL_HI_ALPHA  = 3'd1,
		MUL_SB_W      = 3'd2,
		MUL_LF_RECIP  = 3'd3,
		MUL_RAW_RECIP = 3'd4,
		MUL_K_QUANT   = 3'd5
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_RND  = 2'd1,
		ACC_CH   = 2'd2,
		ACC_ADD  = 2'd3
	} acc_op_t;

	typedef struct packed {
		logic     load_in;
		logic     seed;
		mul_sel_t mul_sel;
		logic     mul_en;
		acc_op_t  acc_op;
		logic     mean_upd;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic gate_ok;
		logic func;
		logic fresh;
		logic out_stall;
	} dp_status_t;

endpackage

@@ rtl/gem_cfg.sv @@
// gem_cfg: configuration register file, written through the cfg channel.
// Depends on gem_pkg.
module gem_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [gem_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [gem_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output gem_pkg::cfg_regs_t                 regs
);
	import gem_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.alpha   <= ALPHA_RESET;
			regs_q.lower   <= '0;
			regs_q.upper   <= '0;
			regs_q.quantum <= QUANT_RESET;
			regs_q.recip   <= RECIP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ALPHA: regs_q.alpha   <= wr_data[ALPHA_BITS-1:0];
				CFG_LOWER: regs_q.lower   <= wr_data[SAMPLE_BITS-1:0];
				CFG_UPPER: regs_q.upper   <= wr_data[SAMPLE_BITS-1:0];
				CFG_QUANT: regs_q.quantum <= wr_data[QUANT_BITS-1:0];
				CFG_RECIP: regs_q.recip   <= wr_data[RECIP_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

@@ rtl/gem_dp.sv @@
// gem_dp: datapath with mean state, one shared 26x26 multiplier, accumulator
// and output register. Driven by gem_ctrl commands; depends on gem_pkg.
module gem_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gem_pkg::dp_cmd_t                      cmd,
	output gem_pkg::dp_status_t                   status,
	input  gem_pkg::cfg_regs_t                    cfg,
	input  logic                                  func_in,
	input  logic signed [gem_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  out_accepted,
	output logic        [gem_pkg::SAMPLE_BITS-1:0] out_raw,
	output logic        [gem_pkg::SAMPLE_BITS-1:0] out_rounded
);
	import gem_pkg::*;

	localparam logic [MEAN_BITS-1:0]   MEAN_MSB = MEAN_BITS'(1) << (MEAN_BITS - 1);
	localparam logic [SAMPLE_BITS-1:0] S_MSB    = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic signed [PROD_BITS-1:0] RND_HALF =
		PROD_BITS'(1) << (ALPHA_BITS - 1);
	localparam logic signed [PROD_BITS-1:0] CH_BIAS =
		PROD_BITS'(1) << (ALPHA_BITS + RECIP_SHIFT - 1);
	localparam logic signed [PROD_BITS-1:0] S_MAX = PROD_BITS'(S_MSB - 1'b1);
	localparam logic signed [PROD_BITS-1:0] S_MIN = -PROD_BITS'(S_MSB);

	logic        [MEAN_BITS-1:0]   mean_q;
	logic                          fresh_q;
	logic        [SAMPLE_BITS-1:0] sample_q;
	logic                          acc_flag_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [PROD_BITS-1:0]   acc_q;
	logic                          out_valid_q;
	logic                          out_acc_q;
	logic        [SAMPLE_BITS-1:0] out_raw_q;
	logic        [SAMPLE_BITS-1:0] out_rounded_q;

	logic                          bounds_zero;
	logic                          gate_ok;
	logic        [ALPHA_BITS-1:0]  lf;
	logic        [SAMPLE_BITS-1:0] hi;
	logic        [SAMPLE_BITS-1:0] sb;
	logic        [ALPHA_BITS:0]    w;
	logic signed [SAMPLE_BITS-1:0] raw;
	logic signed [MUL_BITS-1:0]    k;
	logic signed [MUL_BITS-1:0]    op_a;
	logic signed [MUL_BITS-1:0]    op_b;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [PROD_BITS-1:0]   upd_sum;
	logic        [SAMPLE_BITS-1:0] sat;

	assign bounds_zero = (cfg.lower == '0) && (cfg.upper == '0);
	assign gate_ok = bounds_zero || ((sample_in >= cfg.lower) && (sample_in <= cfg.upper));

	// mean is kept two's complement; the update works in offset binary
	assign lf  = mean_q[ALPHA_BITS-1:0];
	assign hi  = mean_q[MEAN_BITS-1:ALPHA_BITS] ^ S_MSB;
	assign raw = $signed(mean_q[MEAN_BITS-1:ALPHA_BITS]);
	assign sb  = sample_q ^ S_MSB;
	assign w   = ((ALPHA_BITS+1)'(1) << ALPHA_BITS) - (ALPHA_BITS+1)'(cfg.alpha);
	assign k   = acc_q[RECIP_SHIFT +: MUL_BITS];

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_sel)
			MUL_LF_ALPHA: begin
				op_a = MUL_BITS'(lf);
				op_b = MUL_BITS'(cfg.alpha);
			end
			MUL_HI_ALPHA: begin
				op_a = MUL_BITS'(hi);
				op_b = MUL_BITS'(cfg.alpha);
			end
			MUL_SB_W: begin
				op_a = MUL_BITS'(sb);
				op_b = MUL_BITS'(w);
			end
			MUL_LF_RECIP: begin
				op_a = MUL_BITS'(lf);
				op_b = MUL_BITS'(cfg.recip);
			end
			MUL_RAW_RECIP: begin
				op_a = MUL_BITS'(raw);
				op_b = MUL_BITS'(cfg.recip);
			end
			MUL_K_QUANT: begin
				op_a = k;
				op_b = MUL_BITS'(cfg.quantum);
			end
			default: ;
		endcase
	end

	assign prod    = op_a * op_b;
	assign upd_sum = acc_q + prod_q;

	always_comb begin
		if (prod_q > S_MAX) begin
			sat = S_MAX[SAMPLE_BITS-1:0];
		end else if (prod_q < S_MIN) begin
			sat = S_MIN[SAMPLE_BITS-1:0];
		end else begin
			sat = prod_q[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			fresh_q <= 1'b1;
		end else if (cmd.seed) begin
			mean_q  <= {sample_in, {ALPHA_BITS{1'b0}}};
			fresh_q <= func_in;
		end else if (cmd.mean_upd) begin
			mean_q  <= upd_sum[MEAN_BITS-1:0] ^ MEAN_MSB;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q   <= sample_in;
			acc_flag_q <= func_in | gate_ok;
		end
		if (cmd.mul_en) begin
			prod_q <= prod;
		end
		unique case (cmd.acc_op)
			ACC_RND:  acc_q <= (prod_q + RND_HALF) >>> ALPHA_BITS;
			ACC_CH:   acc_q <= (prod_q + CH_BIAS) >>> ALPHA_BITS;
			ACC_ADD:  acc_q <= upd_sum;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_acc_q     <= acc_flag_q;
			out_raw_q     <= mean_q[MEAN_BITS-1:ALPHA_BITS];
			out_rounded_q <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.gate_ok   = gate_ok;
	assign status.func      = func_in;
	assign status.fresh     = fresh_q;
	assign status.out_stall = out_valid_q & ~out_ready;

	assign out_valid    = out_valid_q;
	assign out_accepted = out_acc_q;
	assign out_rounded  = out_rounded_q;
	// snapshot, the next word may already change the mean while this one waits
	assign out_raw      = out_raw_q;

endmodule

@@ rtl/gem_ctrl.sv @@
// gem_ctrl: sequencer for the update and rounding steps of the datapath.
// Depends on gem_pkg.
module gem_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gem_pkg::dp_status_t status,
	output gem_pkg::dp_cmd_t    cmd
);
	import gem_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (status.func || (status.gate_ok && status.fresh)) begin
						cmd.seed  = 1'b1;
						state_nxt = ST_R1;
					end else if (!status.gate_ok) begin
						state_nxt = ST_R1;
					end else begin
						state_nxt = ST_U1;
					end
				end
			end
			ST_U1: begin
				cmd.mul_sel = MUL_LF_ALPHA;
				cmd.mul_en  = 1'b1;
				state_nxt   = ST_U2;
			end
			ST_U2: begin
				cmd.mul_sel = MUL_HI_ALPHA;
				cmd.mul_en  = 1'b1;
				cmd.acc_op  = ACC_RND;
				state_nxt   = ST_U3;
			end
			ST_U3: begin
				cmd.mul_sel = MUL_SB_W;
				cmd.mul_en  = 1'b1;
				cmd.acc_op  = ACC_ADD;
				state_nxt   = ST_U4;
			end
			ST_U4: begin
				cmd.mean_upd = 1'b1;
				state_nxt    = ST_R1;
			end
			ST_R1: begin
				cmd.mul_sel = MUL_LF_RECIP;
				cmd.mul_en  = 1'b1;
				state_nxt   = ST_R2;
			end
			ST_R2: begin
				cmd.mul_sel = MUL_RAW_RECIP;
				cmd.mul_en  = 1'b1;
				cmd.acc_op  = ACC_CH;
				state_nxt   = ST_R3;
			end
			ST_R3: begin
				cmd.acc_op = ACC_ADD;
				state_nxt  = ST_R4;
			end
			ST_R4: begin
				cmd.mul_sel = MUL_K_QUANT;
				cmd.mul_en  = 1'b1;
				state_nxt   = ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/gated_exponential_mean_unit.sv @@
// Gated exponential mean unit: top level joining config registers,
// controller and datapath. Depends on gem_pkg, gem_cfg, gem_ctrl, gem_dp.
//
// Input words on s_*: s_tuser is the function (0 update, 1 restart), s_tdata
// the signed Q15.8 sample. One result word per input word on m_*: m_tuser is
// the accepted flag, m_tdata holds the raw mean and the rounded mean.
// Register writes on cfg_*: cfg_index selects alpha, lower bound, upper bound,
// quantum or quantum reciprocal; cfg_ready is always high. Write only while
// the unit is idle.
// A word is taken in the idle state; an update step then runs through states U1 to U4
// using the shared multiplier, the rounding through R1 to R4, and the result is loaded
// into the output register in the done state, which waits while a full output register
// is stalled by the receiver. A restart, a seeding sample or a gated-out sample skips
// the update step. The single 26x26 multiplier is used for up to six dependent products.
// Reset clears the mean to zero, marks the filter fresh and loads the default
// registers. While the receiver stalls, the finished word waits in the output
// register; the next input word is still taken and worked on, and its result
// is held back until the output register drains.
module gated_exponential_mean_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [gem_pkg::SAMPLE_BITS-1:0]      s_tdata,   // [23:0] sample
	input  logic                                 s_tuser,   // [0] func
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [gem_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // [23:0] raw_mean, [47:24] rounded_mean
	output logic                                 m_tuser,   // [0] accepted
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gem_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [gem_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import gem_pkg::*;

	cfg_regs_t               regs;
	dp_cmd_t                 cmd;
	dp_status_t              status;
	logic [SAMPLE_BITS-1:0]  raw_mean;
	logic [SAMPLE_BITS-1:0]  rounded_mean;

	assign cfg_ready = 1'b1;

	gem_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	gem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gem_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg          (regs),
		.func_in      (s_tuser),
		.sample_in    ($signed(s_tdata)),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_accepted (m_tuser),
		.out_raw      (raw_mean),
		.out_rounded  (rounded_mean)
	);

	assign m_tdata = {rounded_mean, raw_mean};

endmodule

@@ dv/gem_checker.sv @@
`timescale 1ns / 100ps
// gem_checker: watches the register, sample and result channels of the gated
// exponential mean unit, predicts every result word and compares it.
// Depends on gem_pkg.
module gem_checker
	import gem_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [SAMPLE_BITS-1:0]   s_tdata,   // [23:0] sample
	input  logic                     s_tuser,   // [0] func
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,   // [23:0] raw_mean, [47:24] rounded_mean
	input  logic                     m_tuser,   // [0] accepted
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       pending,
	output int                       errors
);

	typedef struct packed {
		logic                          accepted;
		logic signed [SAMPLE_BITS-1:0] raw_mean;
		logic signed [SAMPLE_BITS-1:0] rounded_mean;
	} mean_word_t;

	localparam longint SAT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
	localparam longint SAT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

	cfg_regs_t            regs;
	logic [MEAN_BITS-1:0] mean;
	logic                 fresh;
	mean_word_t           mean_words_q[$];
	mean_word_t           got;
	mean_word_t           want;

	function automatic mean_word_t advance_mean(input logic restart,
		input logic signed [SAMPLE_BITS-1:0] smp);
		mean_word_t w;
		logic       in_window;
		longint     hi, lf, a, sb, nb, raw, ch, num, k, res;
		w.accepted = 1'b1;
		in_window = (regs.lower == '0 && regs.upper == '0) ||
			(smp >= regs.lower && smp <= regs.upper);
		if (restart) begin
			mean = {smp, {ALPHA_BITS{1'b0}}};
			fresh = 1'b1;
		end else if (!in_window) begin
			w.accepted = 1'b0;
		end else if (fresh) begin
			mean = {smp, {ALPHA_BITS{1'b0}}};
			fresh = 1'b0;
		end else begin
			// offset binary keeps all partial products non-negative
			hi = {~mean[MEAN_BITS-1], mean[MEAN_BITS-2:ALPHA_BITS]};
			lf = mean[ALPHA_BITS-1:0];
			sb = {~smp[SAMPLE_BITS-1], smp[SAMPLE_BITS-2:0]};
			a = regs.alpha;
			nb = hi * a + sb * ((64'sd1 <<< ALPHA_BITS) - a)
				+ ((lf * a + (64'sd1 <<< (ALPHA_BITS - 1))) >>> ALPHA_BITS);
			mean = nb[MEAN_BITS-1:0];
			mean[MEAN_BITS-1] = ~mean[MEAN_BITS-1];
		end
		raw = $signed(mean[MEAN_BITS-1:ALPHA_BITS]);
		lf = mean[ALPHA_BITS-1:0];
		ch = (lf * longint'(regs.recip) + (64'sd1 <<< (ALPHA_BITS + RECIP_SHIFT - 1)))
			>>> ALPHA_BITS;
		num = raw * longint'(regs.recip) + ch;
		k = num >>> RECIP_SHIFT;
		res = k * longint'(regs.quantum);
		if (res > SAT_MAX) res = SAT_MAX;
		if (res < SAT_MIN) res = SAT_MIN;
		w.raw_mean = mean[MEAN_BITS-1:ALPHA_BITS];
		w.rounded_mean = res[SAMPLE_BITS-1:0];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{alpha: ALPHA_RESET, lower: '0, upper: '0,
				quantum: QUANT_RESET, recip: RECIP_RESET};
			mean = '0;
			fresh = 1'b1;
			mean_words_q.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALPHA: regs.alpha = cfg_data[ALPHA_BITS-1:0];
					CFG_LOWER: regs.lower = cfg_data[SAMPLE_BITS-1:0];
					CFG_UPPER: regs.upper = cfg_data[SAMPLE_BITS-1:0];
					CFG_QUANT: regs.quantum = cfg_data[QUANT_BITS-1:0];
					CFG_RECIP: regs.recip = cfg_data[RECIP_BITS-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[SAMPLE_BITS-1:0],
					m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]};
				if (mean_words_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: acc %0d raw %0d rnd %0d",
							got.accepted, got.raw_mean, got.rounded_mean);
				end else begin
					want = mean_words_q.pop_front();
					if (got.accepted !== want.accepted || got.raw_mean !== want.raw_mean ||
						got.rounded_mean !== want.rounded_mean) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp acc %0d raw %0d rnd %0d, got acc %0d raw %0d rnd %0d",
								want.accepted, want.raw_mean, want.rounded_mean,
								got.accepted, got.raw_mean, got.rounded_mean);
					end
				end
			end
			if (s_tvalid && s_tready)
				mean_words_q.push_back(advance_mean(s_tuser, s_tdata));
			pending = mean_words_q.size();
		end
	end

endmodule

@@ dv/gated_exponential_mean_unit_tb.sv @@
`timescale 1ns / 100ps
// gated_exponential_mean_unit_tb: directed and random sample words and register
// settings for the gated exponential mean unit, random idling on both streams
// and one long result stall. Depends on gem_pkg and gem_checker.
module gated_exponential_mean_unit_tb;
	import gem_pkg::*;

	localparam logic FUNC_UPDATE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [QUANT_BITS-1:0] Q_MAX = '1;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 125;
	localparam int QUIET_PHASE = 2;
	localparam int HOLD_PHASE  = 4;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 30;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [SAMPLE_BITS-1:0]   s_tdata = '0;     // [23:0] sample
	logic                     s_tuser = 1'b0;   // [0] func
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;          // [23:0] raw_mean, [47:24] rounded_mean
	logic                     m_tuser;          // [0] accepted
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int                       pending;
	int                       errors;

	logic idle_on = 1'b1;
	logic hold_arm = 1'b0;
	logic hold_used = 1'b0;
	int   hold_left = 0;
	int   quiet = 0;

	gated_exponential_mean_unit u_dut (.*);
	gem_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_on || ($urandom_range(99) >= 20);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_word(input logic f, input logic [SAMPLE_BITS-1:0] smp);
		while (idle_on && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= smp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic drain_results;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic load_cfg(input logic [ALPHA_BITS-1:0] a,
		input logic signed [SAMPLE_BITS-1:0] lo, input logic signed [SAMPLE_BITS-1:0] up,
		input logic [QUANT_BITS-1:0] q, input logic [RECIP_BITS-1:0] r);
		drain_results();
		write_reg(CFG_IDX_BITS'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
			CFG_DATA_BITS'($urandom));
		write_reg(CFG_ALPHA, CFG_DATA_BITS'(a));
		write_reg(CFG_LOWER, CFG_DATA_BITS'(lo));
		write_reg(CFG_UPPER, CFG_DATA_BITS'(up));
		write_reg(CFG_QUANT, CFG_DATA_BITS'(q));
		write_reg(CFG_RECIP, r);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(
		input logic signed [SAMPLE_BITS-1:0] lo, input logic signed [SAMPLE_BITS-1:0] up);
		longint span;
		longint v;
		span = longint'(up) - longint'(lo) + 64'sd1;
		case ($urandom_range(9))
			0, 1: v = longint'($urandom);
			2: v = $urandom_range(1) ? longint'(S_MAX) : longint'(S_MIN);
			3: v = longint'(lo) + longint'($urandom_range(6)) - 64'sd3;
			4: v = longint'(up) + longint'($urandom_range(6)) - 64'sd3;
			default: begin
				if (span > 0 && !(lo == '0 && up == '0))
					v = longint'(lo) + longint'($urandom) % span;
				else
					v = longint'($urandom);
			end
		endcase
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic random_phase(input int ph);
		logic [ALPHA_BITS-1:0]         a;
		logic signed [SAMPLE_BITS-1:0] lo, up, t;
		logic [QUANT_BITS-1:0]         q;
		logic [RECIP_BITS-1:0]         r;
		longint                        rl;
		case ($urandom_range(3))
			0: a = '0;
			1: a = '1;
			default: a = ALPHA_BITS'($urandom);
		endcase
		lo = SAMPLE_BITS'($urandom);
		up = SAMPLE_BITS'($urandom);
		case ($urandom_range(7))
			0, 1: begin
				lo = '0;
				up = '0;
			end
			2, 3, 4: begin
				if (lo > up) begin
					t = lo;
					lo = up;
					up = t;
				end
			end
			5, 6: begin
				up = lo + SAMPLE_BITS'($urandom_range(4096));
				if (up < lo) up = S_MAX;
			end
			default: begin
				if (lo < up) begin
					t = lo;
					lo = up;
					up = t;
				end
				if (lo == up) begin
					lo = S_MAX;
					up = S_MIN;
				end
			end
		endcase
		if ($urandom_range(3) != 0)
			q = QUANT_BITS'($urandom_range(255, 1));
		else
			q = QUANT_BITS'($urandom_range(Q_MAX, 1));
		rl = ((64'sd1 <<< RECIP_SHIFT) + longint'(q) / 2) / longint'(q);
		if ($urandom_range(4) == 0)
			rl = longint'($urandom_range(1 << RECIP_SHIFT, 1));
		r = rl[RECIP_BITS-1:0];
		load_cfg(a, lo, up, q, r);
		idle_on <= (ph != QUIET_PHASE);
		for (int i = 0; i < PHASE_WORDS; i++) begin
			if (ph == HOLD_PHASE && i == 10) hold_arm <= 1'b1;
			send_word(($urandom_range(15) == 0) ? FUNC_RESTART : FUNC_UPDATE,
				pick_sample(lo, up));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: open window, first sample seeds
		send_word(FUNC_UPDATE, '0);
		send_word(FUNC_UPDATE, S_MAX);
		send_word(FUNC_UPDATE, S_MIN);
		send_word(FUNC_RESTART, S_MIN);
		send_word(FUNC_UPDATE, S_MIN);
		send_word(FUNC_UPDATE, S_MAX);
		send_word(FUNC_UPDATE, -24'sd1);

		// zero alpha, window edges, restart outside window
		load_cfg('0, -24'sd256, 24'sd256, QUANT_RESET, RECIP_RESET);
		send_word(FUNC_UPDATE, 24'sd256);
		send_word(FUNC_UPDATE, 24'sd257);
		send_word(FUNC_UPDATE, -24'sd256);
		send_word(FUNC_UPDATE, -24'sd257);
		send_word(FUNC_RESTART, S_MAX);
		send_word(FUNC_UPDATE, '0);

		// inverted window, zero quantum
		load_cfg('1, 24'sd100, -24'sd100, '0, 25'd1);
		send_word(FUNC_UPDATE, '0);
		send_word(FUNC_UPDATE, 24'sd100);
		send_word(FUNC_RESTART, 24'h123456);
		send_word(FUNC_UPDATE, -24'sd5);

		// mismatched reciprocal, saturation both ways
		load_cfg(16'd1, '0, '0, Q_MAX, 25'd16777216);
		send_word(FUNC_RESTART, S_MAX);
		send_word(FUNC_RESTART, S_MIN);
		send_word(FUNC_UPDATE, S_MAX);
		send_word(FUNC_UPDATE, 24'sd1);

		load_cfg(16'd32768, '0, '0, 23'd1, 25'd16777216);
		send_word(FUNC_UPDATE, S_MAX);
		send_word(FUNC_UPDATE, S_MIN);
		send_word(FUNC_RESTART, 24'sd128);

		for (int ph = 0; ph < PHASES; ph++)
			random_phase(ph);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ gated_exponential_mean_unit.f @@
rtl/gem_pkg.sv
rtl/gem_cfg.sv
rtl/gem_dp.sv
rtl/gem_ctrl.sv
rtl/gated_exponential_mean_unit.sv
dv/gem_checker.sv
dv/gated_exponential_mean_unit_tb.sv
